FILE: hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define VTP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define VTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/vtp_pkg.sv
// shared types and constants of the vertex transform unit
package vtp_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int MAT_WIDTH   = 32;
   localparam int FRAC_BITS   = 16;
   localparam int NUM_CSR     = 8;
   localparam int CSR_WIDTH   = 2 * MAT_WIDTH;
   localparam int CSR_IDX_W   = 4;

   localparam logic [CSR_WIDTH-1:0] CSR_RESET [NUM_CSR] = '{
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000
   };

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] out_x;
      logic signed [COORD_WIDTH-1:0] out_y;
      logic signed [COORD_WIDTH-1:0] out_z;
      logic                          was_divided;
      logic                          saturated;
   } rsp_type;

endpackage

FILE: hdl/vertex_transform_perspective_unit.sv
// vertex transform pipeline: 4x4 matrix product, perspective divide, clamp
// stages in order: products, partial sums, accumulation, magnitudes, divider setup, quotient bits, output register
// throughput: one beat per cycle while rsp_stall is low; the restoring divider retires one quotient bit per stage
// each stage holds a valid bit and loads whenever it is empty or its successor moves
// reset: synchronous, clears all valid bits and loads the identity matrix
module vertex_transform_perspective_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  vtp_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output vtp_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write,
   input  logic [vtp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [vtp_pkg::CSR_WIDTH-1:0]     csr_wdata
);

   `include "assert_macros.svh"

   localparam int CW    = vtp_pkg::COORD_WIDTH;
   localparam int MW    = vtp_pkg::MAT_WIDTH;
   localparam int FB    = vtp_pkg::FRAC_BITS;
   localparam int IW    = vtp_pkg::CSR_IDX_W;
   localparam int PW    = CW + MW;
   localparam int ACC_W = PW + 2;
   localparam int DV0   = 4;
   localparam int OUTS  = DV0 + CW + 1;
   localparam int NS    = OUTS + 1;
   localparam logic [ACC_W-1:0] W_ONE = ACC_W'(1) << (2 * FB);
   localparam logic [CW-1:0] C_MAX  = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] C_MIN  = {1'b1, {(CW-1){1'b0}}};

   typedef struct packed {
      logic [2:0][ACC_W-1:0] rem;
      logic [2:0][CW-1:0]    quo;
      logic [ACC_W-1:0]      dvsr;
      logic [2:0]            sx;
      logic                  sw;
      logic [2:0]            ovf;
      logic                  dv;
      logic [2:0][CW-1:0]    uout;
      logic [2:0]            usat;
   } div_stage_type;

   logic [vtp_pkg::CSR_WIDTH-1:0] csr_ff [vtp_pkg::NUM_CSR];
   logic signed [MW-1:0]          mat [4][4];
   logic signed [CW-1:0]          pt [3];

   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   logic signed [PW-1:0]    prod_in [4][3];
   logic signed [PW-1:0]    prod_ff [4][3];
   logic signed [MW-1:0]    tr_ff [4];
   logic signed [ACC_W-1:0] s0_in [4];
   logic signed [ACC_W-1:0] s1_in [4];
   logic signed [ACC_W-1:0] s0_ff [4];
   logic signed [ACC_W-1:0] s1_ff [4];
   logic signed [ACC_W-1:0] acc_ff [4];

   logic [ACC_W-1:0] ax_in [3];
   logic [ACC_W-1:0] ax_ff [3];
   logic [ACC_W-1:0] aw_in;
   logic [ACC_W-1:0] aw_ff;
   logic [2:0]       sx_ff;
   logic             sw_ff;
   logic             div_ff;
   logic [CW-1:0]    uout_in [3];
   logic [CW-1:0]    uout_ff [3];
   logic [2:0]       usat_in;
   logic [2:0]       usat_ff;
   logic             div_in;

   div_stage_type dv_ff [CW+1];
   div_stage_type dv_in [CW+1];

   vtp_pkg::rsp_type rsp_in;
   vtp_pkg::rsp_type rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < vtp_pkg::NUM_CSR; i++) begin
            csr_ff[i] <= vtp_pkg::CSR_RESET[i];
         end
      end else if (csr_write && (csr_index < IW'(vtp_pkg::NUM_CSR))) begin
         csr_ff[csr_index[2:0]] <= csr_wdata;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            mat[r][c] = csr_ff[r*2 + c/2][(c%2)*MW +: MW];
         end
      end
   end

   // stage enables
   always_comb begin
      en[NS-1] = ~v_ff[NS-1] | ~rsp_stall;
      for (int k = NS-2; k >= 0; k--) begin
         en[k] = ~v_ff[k] | en[k+1];
      end
   end

   assign req_stall = ~en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // products
   assign pt[0] = req_data.point_x;
   assign pt[1] = req_data.point_y;
   assign pt[2] = req_data.point_z;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 3; r++) begin
            prod_in[c][r] = $signed({{MW{pt[r][CW-1]}}, pt[r]})
                          * $signed({{CW{mat[r][c][MW-1]}}, mat[r][c]});
         end
      end
   end

   // partial sums
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         s0_in[c] = ACC_W'(prod_ff[c][0]) + ACC_W'(prod_ff[c][1]);
         s1_in[c] = ACC_W'(prod_ff[c][2]) + (ACC_W'(tr_ff[c]) <<< FB);
      end
   end

   // magnitudes, divide decision and undivided clamp
   always_comb begin
      div_in = (acc_ff[3] != '0) && (acc_ff[3] != W_ONE);
      aw_in  = acc_ff[3][ACC_W-1] ? -acc_ff[3] : acc_ff[3];
      for (int c = 0; c < 3; c++) begin
         ax_in[c] = acc_ff[c][ACC_W-1] ? -acc_ff[c] : acc_ff[c];
         if ((&acc_ff[c][ACC_W-1:CW-1+FB]) || !(|acc_ff[c][ACC_W-1:CW-1+FB])) begin
            uout_in[c] = acc_ff[c][CW-1+FB:FB];
            usat_in[c] = 1'b0;
         end else begin
            uout_in[c] = acc_ff[c][ACC_W-1] ? C_MIN : C_MAX;
            usat_in[c] = 1'b1;
         end
      end
   end

   // divider setup and one quotient bit per stage
   always_comb begin
      dv_in[0].dvsr = aw_ff;
      dv_in[0].sx   = sx_ff;
      dv_in[0].sw   = sw_ff;
      dv_in[0].dv   = div_ff;
      dv_in[0].usat = usat_ff;
      for (int c = 0; c < 3; c++) begin
         dv_in[0].rem[c]  = ACC_W'(ax_ff[c][ACC_W-1:CW-FB]);
         dv_in[0].ovf[c]  = (ACC_W'(ax_ff[c][ACC_W-1:CW-FB]) >= aw_ff);
         dv_in[0].quo[c]  = {ax_ff[c][CW-FB-1:0], {FB{1'b0}}};
         dv_in[0].uout[c] = uout_ff[c];
      end
      for (int k = 0; k < CW; k++) begin
         dv_in[k+1] = dv_ff[k];
         for (int c = 0; c < 3; c++) begin
            logic [ACC_W:0] r2;
            logic           ge;
            r2 = {dv_ff[k].rem[c], dv_ff[k].quo[c][CW-1]};
            ge = (r2 >= {1'b0, dv_ff[k].dvsr});
            dv_in[k+1].rem[c] = ge ? ACC_W'(r2 - {1'b0, dv_ff[k].dvsr}) : r2[ACC_W-1:0];
            dv_in[k+1].quo[c] = {dv_ff[k].quo[c][CW-2:0], ge};
         end
      end
   end

   // sign, clamp and select
   always_comb begin
      logic [2:0][CW-1:0] res;
      logic [2:0]         sat;
      for (int c = 0; c < 3; c++) begin
         if (!dv_ff[CW].dv) begin
            res[c] = dv_ff[CW].uout[c];
            sat[c] = dv_ff[CW].usat[c];
         end else if (dv_ff[CW].sx[c] ^ dv_ff[CW].sw) begin
            if (dv_ff[CW].ovf[c] || (dv_ff[CW].quo[c] > C_MIN)) begin
               res[c] = C_MIN;
               sat[c] = 1'b1;
            end else begin
               res[c] = -dv_ff[CW].quo[c];
               sat[c] = 1'b0;
            end
         end else begin
            if (dv_ff[CW].ovf[c] || dv_ff[CW].quo[c][CW-1]) begin
               res[c] = C_MAX;
               sat[c] = 1'b1;
            end else begin
               res[c] = dv_ff[CW].quo[c];
               sat[c] = 1'b0;
            end
         end
      end
      rsp_in.out_x       = res[0];
      rsp_in.out_y       = res[1];
      rsp_in.out_z       = res[2];
      rsp_in.was_divided = dv_ff[CW].dv;
      rsp_in.saturated   = |sat;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
         for (int c = 0; c < 4; c++) begin
            tr_ff[c] <= mat[3][c];
         end
      end
      if (en[1]) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
      end
      if (en[2]) begin
         for (int c = 0; c < 4; c++) begin
            acc_ff[c] <= s0_ff[c] + s1_ff[c];
         end
      end
      if (en[3]) begin
         ax_ff   <= ax_in;
         aw_ff   <= aw_in;
         sw_ff   <= acc_ff[3][ACC_W-1];
         div_ff  <= div_in;
         uout_ff <= uout_in;
         usat_ff <= usat_in;
         for (int c = 0; c < 3; c++) begin
            sx_ff[c] <= acc_ff[c][ACC_W-1];
         end
      end
      for (int k = 0; k <= CW; k++) begin
         if (en[DV0+k]) begin
            dv_ff[k] <= dv_in[k];
         end
      end
      if (en[OUTS]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v_ff[OUTS];
   assign rsp_data  = rsp_ff;

   `VTP_ASSERT_NEXT(a_enter, clock, reset, req_valid && !req_stall, v_ff[0])
   `VTP_ASSERT_SAME(a_flow, clock, reset, !rsp_stall, !req_stall)
   `VTP_ASSERT_SAME(a_rem, clock, reset, v_ff[OUTS-1] && dv_ff[CW].dv,
      (dv_ff[CW].rem[0] < dv_ff[CW].dvsr) || dv_ff[CW].ovf[0])

endmodule

FILE: bench/tb_top.sv
// self-checking testbench of the vertex transform unit with a transform predictor
class transform_board;
   logic [63:0] mat [8];
   vtp_pkg::rsp_type pending_q [$];
   int errors;

   function new();
      for (int i = 0; i < 8; i++) mat[i] = vtp_pkg::CSR_RESET[i];
      errors = 0;
   endfunction

   function void set_reg(int idx, logic [63:0] val);
      if (idx < 8) mat[idx] = val;
   endfunction

   function logic signed [31:0] entry(int row, int col);
      logic [63:0] w;
      w = mat[row * 2 + col / 2];
      return (col % 2) ? w[63:32] : w[31:0];
   endfunction

   function vtp_pkg::rsp_type transform(vtp_pkg::req_type r);
      logic signed [127:0] acc [4];
      logic signed [127:0] pt [3];
      logic signed [127:0] e, res;
      logic [127:0] num, den, quo;
      logic divide, sat;
      logic signed [31:0] outv [3];
      vtp_pkg::rsp_type o;
      pt[0] = r.point_x;
      pt[1] = r.point_y;
      pt[2] = r.point_z;
      for (int c = 0; c < 4; c++) begin
         e = entry(3, c);
         acc[c] = e <<< 16;
         for (int k = 0; k < 3; k++) begin
            e = entry(k, c);
            acc[c] = acc[c] + pt[k] * e;
         end
      end
      divide = !(acc[3] == 0 || acc[3] == (128'sd1 <<< 32));
      sat = 1'b0;
      for (int c = 0; c < 3; c++) begin
         if (divide) begin
            num = (acc[c] < 0) ? -acc[c] : acc[c];
            num = num << 16;
            den = (acc[3] < 0) ? -acc[3] : acc[3];
            quo = num / den;
            res = quo;
            if ((acc[c] < 0) != (acc[3] < 0)) res = -res;
         end else begin
            res = acc[c] >>> 16;
         end
         if (res > 128'sh7fff_ffff) begin
            res = 128'sh7fff_ffff;
            sat = 1'b1;
         end else if (res < -128'sh8000_0000) begin
            res = -128'sh8000_0000;
            sat = 1'b1;
         end
         outv[c] = res[31:0];
      end
      o.out_x = outv[0];
      o.out_y = outv[1];
      o.out_z = outv[2];
      o.was_divided = divide;
      o.saturated = sat;
      return o;
   endfunction

   function void note_input(vtp_pkg::req_type r);
      pending_q = {pending_q, transform(r)};
   endfunction

   function void check_result(vtp_pkg::rsp_type a);
      vtp_pkg::rsp_type x;
      if (pending_q.size() == 0) begin
         $error("unexpected result beat %h", a);
         errors++;
         return;
      end
      x = pending_q.pop_front();
      if (a.out_x !== x.out_x) begin
         $error("out_x expected %h actual %h", x.out_x, a.out_x);
         errors++;
      end
      if (a.out_y !== x.out_y) begin
         $error("out_y expected %h actual %h", x.out_y, a.out_y);
         errors++;
      end
      if (a.out_z !== x.out_z) begin
         $error("out_z expected %h actual %h", x.out_z, a.out_z);
         errors++;
      end
      if (a.was_divided !== x.was_divided) begin
         $error("was_divided expected %b actual %b", x.was_divided, a.was_divided);
         errors++;
      end
      if (a.saturated !== x.saturated) begin
         $error("saturated expected %b actual %b", x.saturated, a.saturated);
         errors++;
      end
   endfunction
endclass

module tb_top;

   localparam int ROW0_COLS01 = 0;
   localparam int ROW0_COLS23 = 1;
   localparam int ROW1_COLS23 = 3;
   localparam int ROW2_COLS23 = 5;
   localparam int ROW3_COLS23 = 7;
   localparam int BAD_INDEX_LO = 9;
   localparam int BAD_INDEX_HI = 15;
   localparam int DRAIN_CYCLES = 50;
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_BEATS = 125;

   localparam int MIX_RANDOM = 0;
   localparam int MIX_AFFINE = 1;
   localparam int MIX_PERSPECTIVE = 2;
   localparam int MIX_W_ZERO = 3;
   localparam int MIX_EXTREME = 4;

   localparam int IW = vtp_pkg::CSR_IDX_W;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   vtp_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   vtp_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [vtp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [vtp_pkg::CSR_WIDTH-1:0] csr_wdata = '0;

   transform_board board = new();
   bit idle_en = 1'b1;
   bit hold_start = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;

   vertex_transform_perspective_unit DUT (.*);

   always #2 clock = ~clock;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall = 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else if (hold_start) begin
         hold_start = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = idle_en && ($urandom_range(0, 99) < 37);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_beat(vtp_pkg::req_type d);
      if (idle_en) begin
         while ($urandom_range(0, 99) < 37) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      end
      req_valid = 1'b1;
      req_data = d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_input(d);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (board.pending_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(int idx, logic [63:0] val);
      csr_write = 1'b1;
      csr_index = IW'(idx);
      csr_wdata = val;
      board.set_reg(idx, val);
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   function automatic logic [31:0] small_entry();
      return $urandom_range(0, 32'h3ffff) - 32'h20000;
   endfunction

   function automatic logic [31:0] coord();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2, 3, 4: return $urandom();
         default: return $urandom_range(0, 32'h1f_ffff) - 32'h10_0000;
      endcase
   endfunction

   task automatic load_matrix(int mix);
      logic [31:0] m [8][2];
      for (int i = 0; i < 8; i++) begin
         for (int h = 0; h < 2; h++) begin
            case (mix)
               MIX_RANDOM: m[i][h] = $urandom();
               MIX_EXTREME: m[i][h] = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
               default: m[i][h] = small_entry();
            endcase
         end
      end
      if (mix == MIX_AFFINE || mix == MIX_PERSPECTIVE || mix == MIX_W_ZERO) begin
         m[ROW0_COLS23][1] = '0;
         m[ROW1_COLS23][1] = '0;
         m[ROW2_COLS23][1] = (mix == MIX_PERSPECTIVE) ? 32'h10000 : 32'h0;
         m[ROW3_COLS23][1] = (mix == MIX_AFFINE) ? 32'h10000 : 32'h0;
      end
      for (int i = 0; i < 8; i++) write_reg(i, {m[i][1], m[i][0]});
   endtask

   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      vtp_pkg::req_type d;
      d.point_x = x;
      d.point_y = y;
      d.point_z = z;
      send_beat(d);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // identity after reset, w is exactly one
      send_point(32'h0, 32'h0, 32'h0);
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'h1);
      send_point(32'h10000, 32'hffff_0000, 32'h1234_5678);
      drain();

      // w is zero, extreme coefficients saturate undivided
      load_matrix(MIX_EXTREME);
      write_reg(ROW0_COLS23, 64'h0);
      write_reg(ROW1_COLS23, 64'h0);
      write_reg(ROW2_COLS23, 64'h0);
      write_reg(ROW3_COLS23, 64'h0);
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'h0, 32'h0, 32'h0);
      drain();

      // tiny nonzero w
      write_reg(ROW3_COLS23, {32'h1, 32'h0});
      send_point(32'h10000, 32'hffff_0000, 32'h0);
      send_point(32'h0, 32'h0, 32'h0);
      drain();

      // w of minus one
      write_reg(ROW0_COLS01, {32'h0, 32'h10000});
      write_reg(ROW3_COLS23, {32'hffff_0000, 32'h0});
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'h1);
      send_point(32'h3, 32'hffff_fffd, 32'h8000_0000);
      drain();

      // writes beyond the register file are dropped
      write_reg(BAD_INDEX_LO, 64'hdead_beef_dead_beef);
      write_reg(BAD_INDEX_HI, 64'hffff_ffff_ffff_ffff);
      send_point(32'h2_0000, 32'h5_8000, 32'hfff0_0000);
      send_point(32'h7fff_ffff, 32'h0, 32'h8000_0000);
      drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         load_matrix(ph == 0 ? MIX_EXTREME : $urandom_range(MIX_RANDOM, MIX_W_ZERO));
         idle_en = (ph != 2);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (ph == 3 && n == 40) hold_start = 1'b1;
            if (ph == 4 && n == 60) begin
               req_valid = 1'b0;
               while (board.pending_q.size() > 0) @(posedge clock);
               @(negedge clock);
            end
            send_point(coord(), coord(), coord());
         end
         drain();
      end
      idle_en = 1'b1;

      if (board.errors == 0 && board.pending_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
